### rtl/core/mhpq_pkg.sv
// Package for the min-heap priority queue: key type, field widths,
// operation and status codes, default capacity. No dependencies.
package mhpq_pkg;

	localparam int unsigned KEY_W        = 32;
	localparam int unsigned COUNT_W      = 11;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned DEF_CAPACITY = 1024;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

### rtl/core/mhpq_req_if.sv
// Request channel of the min-heap priority queue: push or pop with a key.
// Depends on mhpq_pkg.
interface mhpq_req_if;
	import mhpq_pkg::*;

	logic valid;
	logic ready;
	logic func;
	key_t key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

### rtl/core/mhpq_rsp_if.sv
// Response channel of the min-heap priority queue: removed key, new top,
// empty flag, entry count and status. Depends on mhpq_pkg.
interface mhpq_rsp_if;
	import mhpq_pkg::*;

	logic                valid;
	logic                ready;
	key_t                removed_value;
	key_t                top_value;
	logic                empty_res;
	logic [COUNT_W-1:0]  count;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output removed_value, output top_value, output empty_res,
		output count, output status, input ready);
	modport sink   (input valid, input removed_value, input top_value, input empty_res,
		input count, input status, output ready);
endinterface

### rtl/core/mhpq_ram.sv
// Heap store: one write port, two registered read ports.
// Depends on mhpq_pkg.
module mhpq_ram #(
	parameter int unsigned DEPTH = mhpq_pkg::DEF_CAPACITY,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  mhpq_pkg::key_t      wdata,
	input  logic [AW-1:0]       raddr0,
	input  logic [AW-1:0]       raddr1,
	output mhpq_pkg::key_t      rdata0,
	output mhpq_pkg::key_t      rdata1
);
	import mhpq_pkg::*;

	key_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

### rtl/core/min_heap_priority_queue.sv
// Binary min-heap priority queue of signed 32-bit keys.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if and mhpq_ram.
//
// req carries a request: func selects push (key appended and sifted up) or
// pop (root removed, last entry moved to the root and sifted down). rsp
// returns one result per request: removed minimum, new top, empty flag,
// entry count and status (ok, push refused when full, pop refused when empty).
//
// The heap sits in one memory with two read ports; the moving key is held in
// a register and each level takes a read state and a compare/write state.
// Push sifts the key up until it reaches the root or is not below its parent;
// pop loads the last entry and sifts it down from the root until the node has
// no children or no child is smaller. Refused requests and a pop that
// empties the heap go straight from idle to the finish state.
// One request is in work at a time; req.ready is high while the block is idle.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; a stalled rsp holds the next finished request.
// Reset empties the heap (count zero); the store itself is not cleared.
module min_heap_priority_queue #(
	parameter int unsigned CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
	input logic          clk,
	input logic          arst_n,
	mhpq_req_if.sink     req,
	mhpq_rsp_if.source   rsp
);
	import mhpq_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_UP_RD  = 7'b0000010,
		S_UP_CMP = 7'b0000100,
		S_LOAD   = 7'b0001000,
		S_DN_RD  = 7'b0010000,
		S_DN_CMP = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       pos_q;
	key_t                val_q;
	key_t                top_q;
	key_t                removed_q;
	logic [STATUS_W-1:0] status_q;
	logic                rsp_valid_q;
	key_t                rsp_removed_q;
	key_t                rsp_top_q;
	logic                rsp_empty_q;
	logic [COUNT_W-1:0]  rsp_count_q;
	logic [STATUS_W-1:0] rsp_status_q;

	logic                we;
	logic [AW-1:0]       waddr;
	key_t                wdata;
	logic [AW-1:0]       raddr0;
	logic [AW-1:0]       raddr1;
	key_t                rdata0;
	key_t                rdata1;

	logic [AW-1:0]       parent;
	logic [AW:0]         lc;
	logic [AW:0]         rc;
	logic [AW:0]         count_ext;
	logic                lc_ok;
	logic                rc_ok;
	logic                pick_right;
	key_t                pick_val;
	logic [AW-1:0]       pick_addr;
	logic                accept;
	logic                fin_load;

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign fin_load   = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	assign parent     = (pos_q - AW'(1)) >> 1;
	assign lc         = {pos_q, 1'b1};
	assign rc         = lc + (AW+1)'(1);
	assign count_ext  = (AW+1)'(count_q);
	assign lc_ok      = lc < count_ext;
	assign rc_ok      = rc < count_ext;
	assign pick_right = rc_ok && (rdata1 < rdata0);
	assign pick_val   = pick_right ? rdata1 : rdata0;
	assign pick_addr  = pick_right ? rc[AW-1:0] : lc[AW-1:0];

	always_comb begin
		raddr0 = AW'(count_q - CW'(1));
		raddr1 = rc[AW-1:0];
		if (state_q == S_UP_RD || state_q == S_UP_CMP) begin
			raddr0 = parent;
		end else if (state_q == S_DN_RD || state_q == S_DN_CMP) begin
			raddr0 = lc[AW-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = val_q;
		unique case (state_q)
			S_UP_RD: begin
				we = (pos_q == '0);
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (val_q < rdata0) begin
					wdata = rdata0;
				end
			end
			S_DN_RD: begin
				we = !lc_ok;
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (pick_val < val_q) begin
					wdata = pick_val;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	mhpq_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.func == FUNC_PUSH) begin
							if (count_q == CW'(CAPACITY)) begin
								state_q <= S_FIN;
							end else begin
								count_q <= count_q + CW'(1);
								state_q <= S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								state_q <= S_FIN;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= (count_q == CW'(1)) ? S_FIN : S_LOAD;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= (val_q < rdata0) ? S_UP_RD : S_FIN;
				end
				S_LOAD: begin
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= lc_ok ? S_DN_CMP : S_FIN;
				end
				S_DN_CMP: begin
					state_q <= (pick_val < val_q) ? S_DN_RD : S_FIN;
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q     <= req.key;
					pos_q     <= count_q[AW-1:0];
					removed_q <= '0;
					status_q  <= STATUS_OK;
					if (req.func == FUNC_PUSH) begin
						if (count_q == CW'(CAPACITY)) begin
							status_q <= STATUS_FULL;
						end
					end else if (count_q == '0) begin
						status_q <= STATUS_EMPTY;
					end else begin
						removed_q <= top_q;
					end
				end
			end
			S_UP_CMP: begin
				if (val_q < rdata0) begin
					pos_q <= parent;
				end
			end
			S_LOAD: begin
				val_q <= rdata0;
				pos_q <= '0;
			end
			S_DN_CMP: begin
				if (pick_val < val_q) begin
					pos_q <= pick_addr;
				end
			end
			default: begin
			end
		endcase
		if (fin_load) begin
			rsp_removed_q <= removed_q;
			rsp_top_q     <= (count_q != '0) ? top_q : '0;
			rsp_empty_q   <= (count_q == '0);
			rsp_count_q   <= COUNT_W'(count_q);
			rsp_status_q  <= status_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = rsp_removed_q;
	assign rsp.top_value     = rsp_top_q;
	assign rsp.empty_res     = rsp_empty_q;
	assign rsp.count         = rsp_count_q;
	assign rsp.status        = rsp_status_q;
endmodule

### rtl/core/mhpq_checker.sv
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue.
module mhpq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input mhpq_pkg::key_t                 rsp_removed_value,
	input mhpq_pkg::key_t                 rsp_top_value,
	input logic                           rsp_empty_res,
	input logic [mhpq_pkg::COUNT_W-1:0]   rsp_count,
	input logic [mhpq_pkg::STATUS_W-1:0]  rsp_status
);
	import mhpq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value) && $stable(rsp_status))
		else $error("response dropped or changed while stalled");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_empty_res |-> rsp_count == '0 && rsp_top_value == '0)
		else $error("empty heap reports entries or a top key");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_empty_res && rsp_removed_value == '0)
		else $error("refused pop reports a removed key or a nonempty heap");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STATUS_FULL |-> !rsp_empty_res && rsp_removed_value == '0)
		else $error("refused push reports a removed key or an empty heap");
endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_removed_value (rsp.removed_value),
	.rsp_top_value     (rsp.top_value),
	.rsp_empty_res     (rsp.empty_res),
	.rsp_count         (rsp.count),
	.rsp_status        (rsp.status)
);
